@@ rtl/core/sha1b_pkg.sv @@
package sha1b_pkg;

	// Initial chaining value, h0 at index 0.
	localparam logic [4:0][31:0] H_INIT = {
		32'hC3D2E1F0, 32'h10325476, 32'h98BADCFE, 32'hEFCDAB89, 32'h67452301
	};

	localparam logic [31:0] K_R0 = 32'h5A827999;
	localparam logic [31:0] K_R1 = 32'h6ED9EBA1;
	localparam logic [31:0] K_R2 = 32'h8F1BBCDC;
	localparam logic [31:0] K_R3 = 32'hCA62C1D6;

	localparam logic [7:0] PAD_MARK = 8'h80;

	localparam int unsigned ROUNDS = 80;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       has_byte;
		logic       last;
	} msg_item_t;

	typedef struct packed {
		logic [31:0] digest_word;
		logic        final_word;
	} digest_item_t;

	// Requests from the byte sequencer to the compression engine.
	typedef struct packed {
		logic        push;
		logic [31:0] push_word;
		logic        start;
		logic        init;
	} core_ctrl_t;

endpackage

@@ rtl/core/sha1b_core.sv @@
module sha1b_core
	import sha1b_pkg::*;
(
	input  logic                  clk,
	input  logic                  arst_n,
	input  core_ctrl_t            ctrl,
	output logic                  busy,
	output logic [4:0][31:0]      chain
);

	localparam logic [1:0] C_IDLE  = 2'd0;
	localparam logic [1:0] C_ROUND = 2'd1;
	localparam logic [1:0] C_ADD   = 2'd2;

	logic [1:0]        state_q;
	logic [6:0]        rnd_q;
	logic [15:0][31:0] w_q;
	logic [4:0][31:0]  vars_q;
	logic [4:0][31:0]  chain_q;

	logic [31:0] w_mix;
	logic [31:0] w_next;
	logic [31:0] f_val;
	logic [31:0] k_val;
	logic [31:0] t_val;
	logic [31:0] va, vb, vc, vd, ve;

	assign busy  = (state_q != C_IDLE);
	assign chain = chain_q;

	assign va = vars_q[0];
	assign vb = vars_q[1];
	assign vc = vars_q[2];
	assign vd = vars_q[3];
	assign ve = vars_q[4];

	// During the rounds the schedule line holds W[t] .. W[t+15]; the oldest word sits at the bottom.
	assign w_mix  = w_q[13] ^ w_q[8] ^ w_q[2] ^ w_q[0];
	assign w_next = {w_mix[30:0], w_mix[31]};

	always_comb begin
		if (rnd_q inside {[7'd0:7'd19]}) begin
			f_val = (vb & vc) | (~vb & vd);
			k_val = K_R0;
		end else if (rnd_q inside {[7'd20:7'd39]}) begin
			f_val = vb ^ vc ^ vd;
			k_val = K_R1;
		end else if (rnd_q inside {[7'd40:7'd59]}) begin
			f_val = (vb & vc) | (vb & vd) | (vc & vd);
			k_val = K_R2;
		end else begin
			f_val = vb ^ vc ^ vd;
			k_val = K_R3;
		end
	end

	assign t_val = {va[26:0], va[31:27]} + f_val + ve + k_val + w_q[0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= C_IDLE;
			rnd_q   <= '0;
			chain_q <= H_INIT;
		end else begin
			case (state_q)
				C_IDLE: begin
					if (ctrl.init) begin
						chain_q <= H_INIT;
					end
					if (ctrl.start) begin
						rnd_q   <= '0;
						state_q <= C_ROUND;
					end
				end
				C_ROUND: begin
					rnd_q <= rnd_q + 7'd1;
					if (rnd_q == 7'(ROUNDS - 1)) begin
						state_q <= C_ADD;
					end
				end
				C_ADD: begin
					for (int i = 0; i < 5; i++) begin
						chain_q[i] <= chain_q[i] + vars_q[i];
					end
					state_q <= C_IDLE;
				end
				default: begin
					state_q <= C_IDLE;
				end
			endcase
		end
	end

	// Schedule line and working variables carry no reset.
	always_ff @(posedge clk) begin
		if (state_q == C_ROUND) begin
			w_q       <= {w_next, w_q[15:1]};
			vars_q[4] <= vd;
			vars_q[3] <= vc;
			vars_q[2] <= {vb[1:0], vb[31:2]};
			vars_q[1] <= va;
			vars_q[0] <= t_val;
		end else begin
			if (ctrl.push) begin
				w_q <= {ctrl.push_word, w_q[15:1]};
			end
			if (ctrl.start) begin
				vars_q <= chain_q;
			end
		end
	end

endmodule

@@ rtl/core/sha1_byte_stream_hasher.sv @@
// SHA-1 hasher taking the message one byte per request and returning the digest as five words.
// Throughput: one byte per cycle until a 64-byte block fills; each compression then holds
// msg_ready low through its 80 rounds and the chaining add, until the engine is idle again.
// After the last request: 9 to 72 padding bytes and one or two compressions, then the five
// digest words in order, each handed over while digest_ready is high.
// Reset (arst_n low, asynchronous) loads the initial chaining value and empties the block.
module sha1_byte_stream_hasher
	import sha1b_pkg::*;
(
	input  logic         clk,
	input  logic         arst_n,
	input  logic         msg_valid,
	output logic         msg_ready,
	input  msg_item_t    msg,
	output logic         digest_valid,
	input  logic         digest_ready,
	output digest_item_t digest
);

	// Sequencer states.
	localparam logic [2:0] S_IN   = 3'd0;
	localparam logic [2:0] S_WAIT = 3'd1;
	localparam logic [2:0] S_PAD  = 3'd2;
	localparam logic [2:0] S_OUT  = 3'd3;

	logic [2:0]  state_q;
	logic [5:0]  pos_q;      // byte position in the current block
	logic [60:0] count_q;    // message length in bytes, wraps like the bit count
	logic [23:0] word_q;     // bytes of the word being assembled
	logic        pad_q;      // the message has ended, padding still to come
	logic        mark_q;     // the 0x80 marker has been placed
	logic        len_ok_q;   // the current block is the one that carries the length
	logic        final_q;    // the running compression is the last one of the message
	logic [2:0]  out_cnt_q;

	core_ctrl_t       ctrl;
	logic             core_busy;
	logic [4:0][31:0] chain;

	logic        msg_acc;
	logic        digest_acc;
	logic        byte_wr;
	logic [7:0]  byte_val;
	logic [63:0] len_bits;
	logic [63:0] len_shift;

	sha1b_core u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (ctrl),
		.busy   (core_busy),
		.chain  (chain)
	);

	assign msg_ready    = (state_q == S_IN);
	assign msg_acc      = msg_valid && msg_ready;
	assign digest_valid = (state_q == S_OUT);
	assign digest_acc   = digest_valid && digest_ready;

	assign digest.digest_word = chain[out_cnt_q];
	assign digest.final_word  = (out_cnt_q == 3'd4);

	// The length field is written big-endian, one byte per padding cycle at positions 56 to 63.
	assign len_bits  = {count_q, 3'b000};
	assign len_shift = len_bits << {pos_q[2:0], 3'b000};

	// One byte enters the block per cycle while message bytes are accepted or padding runs.
	always_comb begin
		byte_wr  = 1'b0;
		byte_val = 8'h00;
		if (msg_acc && msg.has_byte) begin
			byte_wr  = 1'b1;
			byte_val = msg.data_byte;
		end else if (state_q == S_PAD) begin
			byte_wr = 1'b1;
			if (!mark_q) begin
				byte_val = PAD_MARK;
			end else if (len_ok_q && pos_q >= 6'd56) begin
				byte_val = len_shift[63:56];
			end
		end
	end

	always_comb begin
		ctrl.push      = byte_wr && (pos_q[1:0] == 2'b11);
		ctrl.push_word = {word_q, byte_val};
		ctrl.start     = byte_wr && (pos_q == 6'd63);
		ctrl.init      = digest_acc && digest.final_word;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IN;
			pos_q     <= '0;
			count_q   <= '0;
			pad_q     <= 1'b0;
			mark_q    <= 1'b0;
			len_ok_q  <= 1'b0;
			final_q   <= 1'b0;
			out_cnt_q <= '0;
		end else begin
			if (byte_wr) begin
				pos_q <= pos_q + 6'd1;
			end
			case (state_q)
				S_IN: begin
					if (msg_acc) begin
						if (msg.has_byte) begin
							count_q <= count_q + 61'd1;
						end
						if (msg.last) begin
							pad_q <= 1'b1;
						end
						if (ctrl.start) begin
							state_q <= S_WAIT;
						end else if (msg.last) begin
							state_q <= S_PAD;
						end
					end
				end
				S_PAD: begin
					if (!mark_q) begin
						mark_q <= 1'b1;
					end
					if (ctrl.start) begin
						// A full block without the length forces one more block.
						final_q  <= mark_q && len_ok_q;
						len_ok_q <= 1'b1;
						state_q  <= S_WAIT;
					end else if (!mark_q) begin
						len_ok_q <= (pos_q < 6'd56);
					end
				end
				S_WAIT: begin
					if (!core_busy) begin
						if (final_q) begin
							out_cnt_q <= '0;
							state_q   <= S_OUT;
						end else if (pad_q) begin
							state_q <= S_PAD;
						end else begin
							state_q <= S_IN;
						end
					end
				end
				S_OUT: begin
					if (digest_acc) begin
						if (digest.final_word) begin
							state_q  <= S_IN;
							count_q  <= '0;
							pad_q    <= 1'b0;
							mark_q   <= 1'b0;
							len_ok_q <= 1'b0;
							final_q  <= 1'b0;
						end else begin
							out_cnt_q <= out_cnt_q + 3'd1;
						end
					end
				end
				default: begin
					state_q <= S_IN;
				end
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (byte_wr) begin
			word_q <= {word_q[15:0], byte_val};
		end
	end

`ifndef NO_ASSERTIONS
	// Requests are taken only while the compression engine stands still.
	a_ready_idle: assert property (@(posedge clk) disable iff (!arst_n)
		msg_ready |-> !core_busy)
		else $error("request accepted while compression runs");

	// The digest is shown only from a settled chaining value.
	a_out_idle: assert property (@(posedge clk) disable iff (!arst_n)
		digest_valid |-> !core_busy)
		else $error("digest shown while compression runs");

	// Padding always ends on a block boundary before the digest appears.
	a_out_aligned: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(digest_valid) |-> (pos_q == 6'd0))
		else $error("digest shown with a partly filled block");

	// After the fifth word the block is ready for the next message.
	a_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(digest_acc && digest.final_word) |=> (msg_ready && pos_q == 6'd0))
		else $error("block not restarted after the last digest word");
`endif

endmodule

@@ verif/tb_top.sv @@
`timescale 1ns / 1ps

// Self-checking bench for the SHA-1 byte stream hasher.
// Messages go in one byte per request, each ended by a request with last set. A local
// SHA-1 model follows every accepted request and queues the five digest words that it
// expects. A monitor then compares every digest word that the block returns against
// the head of that queue. Both handshakes are throttled by random gaps and stalls, with
// some messages run back to back with no throttling at all.
module tb_top;
	import sha1b_pkg::*;

	logic         clk;
	logic         arst_n;
	logic         msg_valid;
	logic         msg_ready;
	msg_item_t    msg;
	logic         digest_valid;
	logic         digest_ready;
	digest_item_t digest;

	sha1_byte_stream_hasher uut (
		.clk          (clk),
		.arst_n       (arst_n),
		.msg_valid    (msg_valid),
		.msg_ready    (msg_ready),
		.msg          (msg),
		.digest_valid (digest_valid),
		.digest_ready (digest_ready),
		.digest       (digest)
	);

	// Local SHA-1 state: chaining value, the block being filled and the message length
	// in bits. The length wraps modulo 2^64 in the same way as the block's counter.
	logic [31:0] hash_chain [5];
	logic [31:0] hash_block [16];
	logic [63:0] hash_bits;

	// Digest words still owed by the block, oldest first.
	digest_item_t digest_words_due [$];

	int  mismatches;
	int  messages_ended;
	int  bytes_hashed;
	int  words_checked;
	int  ready_wait;
	// While set, neither side inserts gaps or stalls.
	bit  no_throttle;

	initial clk = 1'b0;
	always #5 clk = ~clk;

	task automatic report_mismatch(input string what);
		$display("%0t: mismatch: %s", $realtime, what);
		mismatches++;
	endtask

	function automatic int draw_gap();
		return no_throttle ? 0 : $urandom_range(0, 14);
	endfunction

	function automatic logic [31:0] rotl32(input logic [31:0] v, input int s);
		return (v << s) | (v >> (32 - s));
	endfunction

	function automatic void hash_restart();
		for (int i = 0; i < 5; i++) begin
			hash_chain[i] = H_INIT[i];
		end
		for (int i = 0; i < 16; i++) begin
			hash_block[i] = '0;
		end
		hash_bits = '0;
	endfunction

	// Writes one byte at byte position pos of the block, big-endian within each word.
	// The first byte of a word replaces whatever the word held before.
	function automatic void hash_place_byte(input int pos, input logic [7:0] b);
		int idx;
		int sh;
		idx = (pos >> 2) & 15;
		sh = (3 - (pos & 3)) * 8;
		if ((pos & 3) == 0) begin
			hash_block[idx] = {24'd0, b} << sh;
		end else begin
			hash_block[idx] |= {24'd0, b} << sh;
		end
	endfunction

	// Eighty rounds over the current block, then the add into the chaining value.
	function automatic void hash_compress();
		logic [31:0] w [16];
		logic [31:0] a, b, c, d, e, f, k, wt, t;
		for (int i = 0; i < 16; i++) begin
			w[i] = hash_block[i];
		end
		a = hash_chain[0];
		b = hash_chain[1];
		c = hash_chain[2];
		d = hash_chain[3];
		e = hash_chain[4];
		for (int r = 0; r < ROUNDS; r++) begin
			if (r < 16) begin
				wt = w[r];
			end else begin
				wt = rotl32(w[(r - 3) & 15] ^ w[(r - 8) & 15] ^ w[(r - 14) & 15] ^ w[r & 15], 1);
				w[r & 15] = wt;
			end
			if (r < 20) begin
				f = (b & c) | (~b & d);
				k = K_R0;
			end else if (r < 40) begin
				f = b ^ c ^ d;
				k = K_R1;
			end else if (r < 60) begin
				f = (b & c) | (b & d) | (c & d);
				k = K_R2;
			end else begin
				f = b ^ c ^ d;
				k = K_R3;
			end
			t = rotl32(a, 5) + f + e + k + wt;
			e = d;
			d = c;
			c = rotl32(b, 30);
			b = a;
			a = t;
		end
		hash_chain[0] += a;
		hash_chain[1] += b;
		hash_chain[2] += c;
		hash_chain[3] += d;
		hash_chain[4] += e;
	endfunction

	// Follows one accepted request. A byte is taken before the end of the message is
	// handled; the end adds the pad mark, zeros, the length and queues the digest.
	function automatic void hash_take_request(input msg_item_t item);
		int pos;
		digest_item_t due_word;
		if (item.has_byte) begin
			pos = int'(hash_bits[8:3]);
			hash_place_byte(pos, item.data_byte);
			hash_bits += 64'd8;
			bytes_hashed++;
			if (pos == 63) begin
				hash_compress();
			end
		end
		if (item.last) begin
			pos = int'(hash_bits[8:3]);
			hash_place_byte(pos, PAD_MARK);
			pos++;
			// No room left for the length: pad out this block and start another.
			if (pos > 56) begin
				while (pos < 64) begin
					hash_place_byte(pos, 8'h00);
					pos++;
				end
				hash_compress();
				pos = 0;
			end
			while (pos < 56) begin
				hash_place_byte(pos, 8'h00);
				pos++;
			end
			hash_block[14] = hash_bits[63:32];
			hash_block[15] = hash_bits[31:0];
			hash_compress();
			for (int i = 0; i < 5; i++) begin
				due_word.digest_word = hash_chain[i];
				due_word.final_word = (i == 4);
				digest_words_due.insert(digest_words_due.size(), due_word);
			end
			messages_ended++;
			hash_restart();
		end
	endfunction

	// Presents one request after a random gap and returns at the edge that accepts it.
	// Valid is only lowered when a gap follows, so it never drops and rises in one step.
	task automatic send_request(input logic [7:0] b, input logic has, input logic fin);
		int gap;
		msg_item_t item;
		gap = draw_gap();
		item.data_byte = b;
		item.has_byte = has;
		item.last = fin;
		if (gap > 0) begin
			msg_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		msg <= item;
		msg_valid <= 1'b1;
		do begin
			@(posedge clk);
		end while (!msg_ready);
		hash_take_request(item);
	endtask

	// Sends a whole message of len random bytes. The end is marked either on the final
	// byte or by a separate request that carries no byte. With noise set, idle requests
	// with random, ignored bytes are sprinkled in between.
	task automatic send_message(input int len, input bit separate_end, input bit noise);
		for (int i = 0; i < len; i++) begin
			if (noise && $urandom_range(0, 9) == 0) begin
				send_request(8'($urandom_range(0, 255)), 1'b0, 1'b0);
			end
			send_request(8'($urandom_range(0, 255)), 1'b1, (i == len - 1) && !separate_end);
		end
		if (len == 0 || separate_end) begin
			send_request(8'($urandom_range(0, 255)), 1'b0, 1'b1);
		end
	endtask

	// Short hand-picked cases: the empty message, ignored bytes, idle requests, single bytes
	// at both extremes, the classic three-byte message and a two-byte one with a separate end.
	task automatic test_directed_edges();
		no_throttle = 1'b0;
		send_request(8'hA5, 1'b0, 1'b1);
		send_request(8'h5A, 1'b0, 1'b0);
		send_request(8'hFF, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b1);
		send_request(8'hFF, 1'b1, 1'b1);
		send_request(8'h61, 1'b1, 1'b0);
		send_request(8'h62, 1'b1, 1'b0);
		send_request(8'h63, 1'b1, 1'b1);
		send_request(8'hFF, 1'b1, 1'b0);
		send_request(8'h00, 1'b0, 1'b0);
		send_request(8'h00, 1'b1, 1'b0);
		send_request(8'hC3, 1'b0, 1'b1);
		no_throttle = 1'b1;
		send_request(8'h00, 1'b0, 1'b1);
		send_request(8'h80, 1'b1, 1'b1);
	endtask

	// Lengths around the point where the length field no longer fits in the final block,
	// and exactly one full block.
	task automatic test_block_boundaries();
		no_throttle = 1'b0;
		send_message(55, 1'b0, 1'b0);
		send_message(56, 1'b1, 1'b0);
		no_throttle = 1'b1;
		send_message(64, 1'b0, 1'b0);
	endtask

	// Random messages, mostly short, some spanning up to three blocks, with throttling
	// switched off for about one message in four.
	task automatic test_random_messages();
		int budget;
		int len;
		int sel;
		budget = 260;
		while (budget > 0) begin
			sel = $urandom_range(0, 9);
			if (sel < 6) begin
				len = $urandom_range(0, 8);
			end else if (sel < 9) begin
				len = $urandom_range(9, 66);
			end else begin
				len = $urandom_range(67, 130);
			end
			no_throttle = ($urandom_range(0, 3) == 0);
			send_message(len, 1'($urandom_range(0, 1)), 1'b1);
			budget -= (len > 0) ? len : 1;
		end
	endtask

	// Result side: before each digest word the receiver stalls for a random number of
	// the cycles in which a word is on offer.
	initial begin
		digest_ready <= 1'b0;
		ready_wait = 0;
		@(posedge arst_n);
		ready_wait = draw_gap();
		forever begin
			@(posedge clk);
			if (digest_valid && digest_ready) begin
				ready_wait = draw_gap();
			end
			if (ready_wait > 0) begin
				digest_ready <= 1'b0;
				if (digest_valid) begin
					ready_wait--;
				end
			end else begin
				digest_ready <= 1'b1;
			end
		end
	end

	// Checks each digest word taken at an edge against the oldest one owed.
	always @(posedge clk) begin
		digest_item_t due;
		if (arst_n && digest_valid && digest_ready) begin
			if (digest_words_due.size() == 0) begin
				report_mismatch($sformatf("digest word %h with none owed", digest.digest_word));
			end else begin
				due = digest_words_due.pop_front();
				words_checked++;
				if (digest.digest_word !== due.digest_word) begin
					report_mismatch($sformatf("digest_word %h, wanted %h",
						digest.digest_word, due.digest_word));
				end
				if (digest.final_word !== due.final_word) begin
					report_mismatch($sformatf("final_word %b, wanted %b",
						digest.final_word, due.final_word));
				end
			end
		end
	end

	initial begin
		#3_000_000;
		$display("sha1_byte_stream_hasher regression: fail");
		$finish;
	end

	initial begin
		mismatches = 0;
		messages_ended = 0;
		bytes_hashed = 0;
		words_checked = 0;
		no_throttle = 1'b0;
		hash_restart();
		arst_n <= 1'b0;
		msg_valid <= 1'b0;
		msg <= '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_directed_edges();
		test_block_boundaries();
		test_random_messages();
		msg_valid <= 1'b0;

		while (digest_words_due.size() != 0) begin
			@(posedge clk);
		end
		repeat (20) @(posedge clk);

		$display("Hashed %0d messages holding %0d bytes in total.", messages_ended, bytes_hashed);
		$display("Checked %0d digest words under random gaps and stalls.", words_checked);
		if (mismatches == 0) begin
			$display("sha1_byte_stream_hasher regression: pass");
		end else begin
			$display("sha1_byte_stream_hasher regression: fail");
		end
		$finish;
	end

endmodule
